// ----- sv/wfm_pkg.sv -----
// ----------------------------------------------------------------------------
// wfm_pkg
// Shared types and constants for the wall-follow motion unit: sensor and
// result transaction formats, configuration set, state and command codes.
// ----------------------------------------------------------------------------
package wfm_pkg;

    localparam int DIST_W  = 10;
    localparam int CODE_W  = 3;
    localparam int CFG_IDX_W = 3;

    // Configuration register indexes
    localparam logic [CFG_IDX_W-1:0] CFG_NEAR_LIMIT = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_OPEN_LIMIT = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_FAST_LIMIT = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_LANE_LOW   = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_LANE_HIGH  = 3'd4;

    // Configuration reset values
    localparam logic [DIST_W-1:0] NEAR_LIMIT_RST = 10'd25;
    localparam logic [DIST_W-1:0] OPEN_LIMIT_RST = 10'd35;
    localparam logic [DIST_W-1:0] FAST_LIMIT_RST = 10'd40;
    localparam logic [DIST_W-1:0] LANE_LOW_RST   = 10'd22;
    localparam logic [DIST_W-1:0] LANE_HIGH_RST  = 10'd23;

    // Wall-situation states
    typedef enum logic [CODE_W-1:0] {
        W_START = 3'd0,
        W_FWD   = 3'd1,
        W_ADJL  = 3'd2,
        W_ADJR  = 3'd3,
        W_FREEL = 3'd4,
        W_FREER = 3'd5,
        W_SPIN  = 3'd6
    } wall_state_t;

    // Motion states (codes track the wall states one to one)
    typedef enum logic [CODE_W-1:0] {
        M_STOP   = 3'd0,
        M_FRONT  = 3'd1,
        M_LEFT   = 3'd2,
        M_RIGHT  = 3'd3,
        M_TURNL  = 3'd4,
        M_TURNR  = 3'd5,
        M_ROTATE = 3'd6
    } move_state_t;

    // Motor commands
    typedef enum logic [CODE_W-1:0] {
        C_STOP  = 3'd0,
        C_FAST  = 3'd1,
        C_SLOW  = 3'd2,
        C_ADJL  = 3'd3,
        C_ADJR  = 3'd4,
        C_SPINL = 3'd5,
        C_SPINR = 3'd6
    } motion_cmd_t;

    typedef struct packed {
        logic [DIST_W-1:0] front_dist;
        logic [DIST_W-1:0] left_dist;
        logic [DIST_W-1:0] right_dist;
    } sample_t;

    typedef struct packed {
        logic [CODE_W-1:0] motion_cmd;
        logic [CODE_W-1:0] wall_mode;
        logic [CODE_W-1:0] move_mode;
    } result_t;

    typedef struct packed {
        logic [DIST_W-1:0] near_limit;
        logic [DIST_W-1:0] open_limit;
        logic [DIST_W-1:0] fast_limit;
        logic [DIST_W-1:0] lane_low;
        logic [DIST_W-1:0] lane_high;
    } cfg_t;

endpackage

// ----- sv/wall_follow_motion_fsm_unit.sv -----
// ----------------------------------------------------------------------------
// wall_follow_motion_fsm_unit
// Wall-following motion controller: one sensor sample in, one motor
// command with the updated wall and motion states out.
// ----------------------------------------------------------------------------
// Path: an accepted sample goes into the input register, then through the
// decision logic into the result register once the result slot is free.
// Throughput: one transaction per cycle while out_stall is low; both states
// update as each sample moves from the input into the result register.
// Reset: states go to start/stop, thresholds to their defaults, pipe empty.
// ----------------------------------------------------------------------------
module wall_follow_motion_fsm_unit (
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           cfg_wr_en,
    input  logic [wfm_pkg::CFG_IDX_W-1:0]  cfg_index,
    input  logic [wfm_pkg::DIST_W-1:0]     cfg_data,
    input  logic                           in_valid,
    output logic                           in_stall,
    input  wfm_pkg::sample_t               in_data,
    output logic                           out_valid,
    input  logic                           out_stall,
    output wfm_pkg::result_t               out_data
);
    import wfm_pkg::*;

    cfg_t        cfg;

    logic        in_valid_reg;
    sample_t     sample_reg;
    logic        out_valid_reg;
    result_t     result_reg;
    wall_state_t wall_state_reg;
    move_state_t move_state_reg;

    motion_cmd_t cmd;
    wall_state_t wall_state_next;
    move_state_t move_state_next;
    result_t     result_next;

    logic        out_free;
    logic        advance;
    logic        take_in;

    wfm_cfg_regs u_cfg (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_wr_en (cfg_wr_en),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .cfg       (cfg)
    );

    wfm_decide u_decide (
        .sample          (sample_reg),
        .cfg             (cfg),
        .wall_state      (wall_state_reg),
        .move_state      (move_state_reg),
        .cmd             (cmd),
        .wall_state_next (wall_state_next),
        .move_state_next (move_state_next)
    );

    // Flow control: result slot frees when empty or being taken
    assign out_free = !out_valid_reg || !out_stall;
    assign advance  = in_valid_reg && out_free;
    assign in_stall = in_valid_reg && !out_free;
    assign take_in  = in_valid && !in_stall;

    assign result_next.motion_cmd = cmd;
    assign result_next.wall_mode  = wall_state_next;
    assign result_next.move_mode  = move_state_next;

    // Control and state registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg   <= 1'b0;
            out_valid_reg  <= 1'b0;
            wall_state_reg <= W_START;
            move_state_reg <= M_STOP;
        end
        else
        begin
            if (take_in)
                in_valid_reg <= 1'b1;
            else if (advance)
                in_valid_reg <= 1'b0;

            if (advance)
                out_valid_reg <= 1'b1;
            else if (!out_stall)
                out_valid_reg <= 1'b0;

            if (advance)
            begin
                wall_state_reg <= wall_state_next;
                move_state_reg <= move_state_next;
            end
        end
    end

    // Payload registers
    always_ff @(posedge clk)
    begin
        if (take_in)
            sample_reg <= in_data;
        if (advance)
            result_reg <= result_next;
    end

    assign out_valid = out_valid_reg;
    assign out_data  = result_reg;

endmodule

// ----- sv/wfm_cfg_regs.sv -----
// ----------------------------------------------------------------------------
// wfm_cfg_regs
// Threshold register file, written through a simple indexed write port.
// Writes to unknown indexes are dropped.
// ----------------------------------------------------------------------------
module wfm_cfg_regs (
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           cfg_wr_en,
    input  logic [wfm_pkg::CFG_IDX_W-1:0]  cfg_index,
    input  logic [wfm_pkg::DIST_W-1:0]     cfg_data,
    output wfm_pkg::cfg_t                  cfg
);
    import wfm_pkg::*;

    cfg_t cfg_reg;
    cfg_t cfg_next;

    // Decode the write
    always_comb
    begin
        cfg_next = cfg_reg;
        if (cfg_wr_en)
        begin
            case (cfg_index)
                CFG_NEAR_LIMIT: cfg_next.near_limit = cfg_data;
                CFG_OPEN_LIMIT: cfg_next.open_limit = cfg_data;
                CFG_FAST_LIMIT: cfg_next.fast_limit = cfg_data;
                CFG_LANE_LOW:   cfg_next.lane_low   = cfg_data;
                CFG_LANE_HIGH:  cfg_next.lane_high  = cfg_data;
                default:        cfg_next = cfg_reg;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.near_limit <= NEAR_LIMIT_RST;
            cfg_reg.open_limit <= OPEN_LIMIT_RST;
            cfg_reg.fast_limit <= FAST_LIMIT_RST;
            cfg_reg.lane_low   <= LANE_LOW_RST;
            cfg_reg.lane_high  <= LANE_HIGH_RST;
        end
        else
        begin
            cfg_reg <= cfg_next;
        end
    end

    assign cfg = cfg_reg;

endmodule

// ----- sv/wfm_decide.sv -----
// ----------------------------------------------------------------------------
// wfm_decide
// Combinational decision logic: motor command from the current motion
// state and sample, next wall and motion states from the states and sample.
// ----------------------------------------------------------------------------
module wfm_decide (
    input  wfm_pkg::sample_t       sample,
    input  wfm_pkg::cfg_t          cfg,
    input  wfm_pkg::wall_state_t   wall_state,
    input  wfm_pkg::move_state_t   move_state,
    output wfm_pkg::motion_cmd_t   cmd,
    output wfm_pkg::wall_state_t   wall_state_next,
    output wfm_pkg::move_state_t   move_state_next
);
    import wfm_pkg::*;

    logic [DIST_W-1:0] f;
    logic [DIST_W-1:0] l;
    logic [DIST_W-1:0] r;

    // Threshold compares
    logic fo;
    logic l_near, r_near;
    logic l_open, r_open;
    logic moving, freed, recov;

    // Lane keeping: in window -> fast, beyond window -> toward, else away
    function automatic motion_cmd_t lane_cmd(
        input logic [DIST_W-1:0] d,
        input logic [DIST_W-1:0] lo,
        input logic [DIST_W-1:0] hi,
        input motion_cmd_t       toward,
        input motion_cmd_t       away
    );
        motion_cmd_t res;
        if (d <= hi && d >= lo)
            res = C_FAST;
        else if (d > hi)
            res = toward;
        else
            res = away;
        return res;
    endfunction

    assign f = sample.front_dist;
    assign l = sample.left_dist;
    assign r = sample.right_dist;

    assign fo     = f > cfg.near_limit;
    assign l_near = l <= cfg.near_limit;
    assign r_near = r <= cfg.near_limit;
    assign l_open = l >= cfg.open_limit;
    assign r_open = r >= cfg.open_limit;

    assign moving = (wall_state == W_FWD) || (wall_state == W_ADJL) ||
                    (wall_state == W_ADJR);
    assign freed  = (wall_state == W_FREEL) || (wall_state == W_FREER);
    assign recov  = freed || (wall_state == W_SPIN);

    // Motor command from the current motion state
    always_comb
    begin
        case (move_state)
            M_STOP:   cmd = C_STOP;
            M_FRONT:  cmd = (f > cfg.fast_limit) ? C_FAST : C_SLOW;
            M_LEFT:   cmd = lane_cmd(l, cfg.lane_low, cfg.lane_high, C_ADJL, C_ADJR);
            M_RIGHT:  cmd = lane_cmd(r, cfg.lane_low, cfg.lane_high, C_ADJR, C_ADJL);
            M_TURNL:  cmd = C_SPINL;
            M_TURNR:  cmd = C_SPINR;
            M_ROTATE: cmd = C_SPINR;
            default:  cmd = C_STOP;
        endcase
    end

    // Wall-situation transitions, first matching rule wins
    always_comb
    begin
        if (wall_state == W_START && fo && !r_near && !l_near)
            wall_state_next = W_FWD;
        else if ((wall_state == W_START || wall_state == W_FWD ||
                  wall_state == W_ADJR) && fo && l_near)
            wall_state_next = W_ADJL;
        else if ((wall_state == W_START || wall_state == W_FWD ||
                  wall_state == W_ADJL) && fo && r_near)
            wall_state_next = W_ADJR;
        else if ((wall_state == W_ADJL || wall_state == W_ADJR) && fo &&
                 (r > cfg.open_limit) && (l > cfg.open_limit))
            wall_state_next = W_FWD;
        else if (moving && !fo && r_near && l_open)
            wall_state_next = W_FREEL;
        else if (moving && !fo && r_open && l_near)
            wall_state_next = W_FREER;
        else if (moving && !fo && r_open && l_open)
            wall_state_next = W_FREER;
        else if (freed && fo && !r_near && !l_near)
            wall_state_next = W_FWD;
        else if (freed && fo && r_near && !l_near)
            wall_state_next = W_ADJR;
        else if (freed && fo && !r_near && l_near)
            wall_state_next = W_ADJL;
        else if (moving && !fo && !r_open && !l_open)
            wall_state_next = W_SPIN;
        else if (recov && fo && !r_near && !l_near)
            wall_state_next = W_FWD;
        else if (recov && fo && r_near && !l_near)
            wall_state_next = W_ADJR;
        else if (recov && fo && !r_near && l_near)
            wall_state_next = W_ADJL;
        else
            wall_state_next = wall_state;
    end

    // Motion state follows the current wall state, holds while at start
    always_comb
    begin
        case (wall_state)
            W_FWD:   move_state_next = M_FRONT;
            W_ADJL:  move_state_next = M_LEFT;
            W_ADJR:  move_state_next = M_RIGHT;
            W_FREEL: move_state_next = M_TURNL;
            W_FREER: move_state_next = M_TURNR;
            W_SPIN:  move_state_next = M_ROTATE;
            default: move_state_next = move_state;
        endcase
    end

endmodule

// ----- bench/wall_follow_motion_fsm_unit_checker.sv -----
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// wall_follow_motion_fsm_unit_checker
// Watches the configuration port and both transaction channels of the
// wall-follow motion unit. Keeps its own copy of the thresholds and of the
// wall and motion states, predicts the motor command and the updated states
// for every accepted sample, and compares each accepted result with the
// oldest prediction field by field.
// ----------------------------------------------------------------------------
module wall_follow_motion_fsm_unit_checker (
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           cfg_wr_en,
    input  logic [wfm_pkg::CFG_IDX_W-1:0]  cfg_index,
    input  logic [wfm_pkg::DIST_W-1:0]     cfg_data,
    input  logic                           in_valid,
    input  logic                           in_stall,
    input  wfm_pkg::sample_t               in_data,
    input  logic                           out_valid,
    input  logic                           out_stall,
    input  wfm_pkg::result_t               out_data,
    output int unsigned                    failures,
    output int unsigned                    outstanding
);
    import wfm_pkg::*;

    cfg_t        thresholds;
    wall_state_t wall_q;
    move_state_t move_q;
    result_t     predicted_results[$];

    initial failures = 0;

    // Lane keeping: inside the window runs fast, beyond it steers toward
    // the wall, short of it steers away
    function automatic motion_cmd_t lane_steer(logic [DIST_W-1:0] side,
                                               motion_cmd_t toward,
                                               motion_cmd_t away);
        if (side <= thresholds.lane_high && side >= thresholds.lane_low)
            return C_FAST;
        if (side > thresholds.lane_high)
            return toward;
        return away;
    endfunction

    // Motor command from the current motion state
    function automatic motion_cmd_t motor_cmd_for(move_state_t m, sample_t s);
        case (m)
            M_STOP:   return C_STOP;
            M_FRONT:  return (s.front_dist > thresholds.fast_limit) ? C_FAST : C_SLOW;
            M_LEFT:   return lane_steer(s.left_dist, C_ADJL, C_ADJR);
            M_RIGHT:  return lane_steer(s.right_dist, C_ADJR, C_ADJL);
            M_TURNL:  return C_SPINL;
            M_TURNR:  return C_SPINR;
            M_ROTATE: return C_SPINR;
            default:  return C_STOP;
        endcase
    endfunction

    // Wall-situation transition; first matching rule wins, else hold
    function automatic wall_state_t wall_after(wall_state_t w, sample_t s);
        logic front_clear, l_near, r_near, l_open, r_open;
        logic l_wide, r_wide, cruising, freed, recovering;
        front_clear = s.front_dist > thresholds.near_limit;
        l_near      = s.left_dist <= thresholds.near_limit;
        r_near      = s.right_dist <= thresholds.near_limit;
        l_open      = s.left_dist >= thresholds.open_limit;
        r_open      = s.right_dist >= thresholds.open_limit;
        l_wide      = s.left_dist > thresholds.open_limit;
        r_wide      = s.right_dist > thresholds.open_limit;
        cruising    = (w == W_FWD) || (w == W_ADJL) || (w == W_ADJR);
        freed       = (w == W_FREEL) || (w == W_FREER);
        recovering  = freed || (w == W_SPIN);

        if (w == W_START && front_clear && !r_near && !l_near) return W_FWD;
        if ((w == W_START || w == W_FWD || w == W_ADJR) && front_clear && l_near)
            return W_ADJL;
        if ((w == W_START || w == W_FWD || w == W_ADJL) && front_clear && r_near)
            return W_ADJR;
        if ((w == W_ADJL || w == W_ADJR) && front_clear && r_wide && l_wide) return W_FWD;
        if (cruising && !front_clear && r_near && l_open) return W_FREEL;
        if (cruising && !front_clear && r_open && l_near) return W_FREER;
        if (cruising && !front_clear && r_open && l_open) return W_FREER;
        if (freed && front_clear && !r_near && !l_near) return W_FWD;
        if (freed && front_clear && r_near && !l_near) return W_ADJR;
        if (freed && front_clear && !r_near && l_near) return W_ADJL;
        if (cruising && !front_clear && !r_open && !l_open) return W_SPIN;
        if (recovering && front_clear && !r_near && !l_near) return W_FWD;
        if (recovering && front_clear && r_near && !l_near) return W_ADJR;
        if (recovering && front_clear && !r_near && l_near) return W_ADJL;
        return w;
    endfunction

    // Motion state follows the wall state, except while still at start
    function automatic move_state_t move_after(move_state_t m, wall_state_t w);
        if (w >= W_FWD && w <= W_SPIN)
            return move_state_t'(w);
        return m;
    endfunction

    // Predict one sample and advance the state copy
    task automatic advance_controller(input sample_t s);
        result_t     r;
        wall_state_t w_next;
        move_state_t m_next;
        r.motion_cmd = motor_cmd_for(move_q, s);
        w_next       = wall_after(wall_q, s);
        m_next       = move_after(move_q, wall_q);
        wall_q       = w_next;
        move_q       = m_next;
        r.wall_mode  = w_next;
        r.move_mode  = m_next;
        predicted_results.push_back(r);
    endtask

    // Compare one accepted result with the oldest prediction
    task automatic check_result(input result_t got);
        result_t want;
        if (predicted_results.size() == 0)
        begin
            $error("result transaction with no prediction pending: %h", got);
            failures++;
        end
        else
        begin
            want = predicted_results.pop_front();
            if (got.motion_cmd !== want.motion_cmd)
            begin
                $error("motion_cmd: expected %0d, actual %0d",
                       want.motion_cmd, got.motion_cmd);
                failures++;
            end
            if (got.wall_mode !== want.wall_mode)
            begin
                $error("wall_mode: expected %0d, actual %0d",
                       want.wall_mode, got.wall_mode);
                failures++;
            end
            if (got.move_mode !== want.move_mode)
            begin
                $error("move_mode: expected %0d, actual %0d",
                       want.move_mode, got.move_mode);
                failures++;
            end
        end
    endtask

    // Monitor: register writes, then results, then new samples
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            thresholds.near_limit = NEAR_LIMIT_RST;
            thresholds.open_limit = OPEN_LIMIT_RST;
            thresholds.fast_limit = FAST_LIMIT_RST;
            thresholds.lane_low   = LANE_LOW_RST;
            thresholds.lane_high  = LANE_HIGH_RST;
            wall_q                = W_START;
            move_q                = M_STOP;
            predicted_results.delete();
            outstanding           = 0;
        end
        else
        begin
            if (cfg_wr_en)
            begin
                case (cfg_index)
                    CFG_NEAR_LIMIT: thresholds.near_limit = cfg_data;
                    CFG_OPEN_LIMIT: thresholds.open_limit = cfg_data;
                    CFG_FAST_LIMIT: thresholds.fast_limit = cfg_data;
                    CFG_LANE_LOW:   thresholds.lane_low   = cfg_data;
                    CFG_LANE_HIGH:  thresholds.lane_high  = cfg_data;
                    default: ;
                endcase
            end
            if (out_valid && !out_stall)
                check_result(out_data);
            if (in_valid && !in_stall)
                advance_controller(in_data);
            outstanding = predicted_results.size();
        end
    end

endmodule

// ----- bench/wall_follow_motion_fsm_unit_tb.sv -----
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// wall_follow_motion_fsm_unit_tb
// Drives sensor samples into the wall-follow motion unit across several
// threshold settings (defaults, zeros, full scale, empty lane window,
// thresholds out of order, random), with bursty input and a stalling
// result side. A checker beside the unit predicts and compares.
// ----------------------------------------------------------------------------
module wall_follow_motion_fsm_unit_tb;
    import wfm_pkg::*;

    localparam int CYCLE_LIMIT     = 400000;
    localparam int SETTING_COUNT   = 8;
    localparam int ITEMS_PER_PHASE = 213;
    localparam int LONG_HOLD       = 80;
    localparam int DRAIN_CYCLES    = 8;
    localparam logic [DIST_W-1:0]    DIST_MAX     = '1;

    logic        clk;
    logic        rst_n;
    logic        cfg_wr_en;
    logic [CFG_IDX_W-1:0] cfg_index;
    logic [DIST_W-1:0]    cfg_data;
    logic        in_valid;
    logic        in_stall;
    sample_t     in_data;
    logic        out_valid;
    logic        out_stall;
    result_t     out_data;

    int unsigned failures;
    int unsigned outstanding;
    int unsigned cycle_count;
    logic        hold_req;
    logic        hold_done;
    cfg_t        active_cfg;

    wall_follow_motion_fsm_unit DUT (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_wr_en (cfg_wr_en),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .in_valid  (in_valid),
        .in_stall  (in_stall),
        .in_data   (in_data),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .out_data  (out_data)
    );

    wall_follow_motion_fsm_unit_checker u_checker (
        .clk         (clk),
        .rst_n       (rst_n),
        .cfg_wr_en   (cfg_wr_en),
        .cfg_index   (cfg_index),
        .cfg_data    (cfg_data),
        .in_valid    (in_valid),
        .in_stall    (in_stall),
        .in_data     (in_data),
        .out_valid   (out_valid),
        .out_stall   (out_stall),
        .out_data    (out_data),
        .failures    (failures),
        .outstanding (outstanding)
    );

    // Clock
    initial
    begin
        clk = 1'b0;
        forever #1 clk = ~clk;
    end

    // Watchdog
    initial cycle_count = 0;
    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT)
        begin
            $display("Verification failed");
            $finish;
        end
    end

    // Result side: stall modes that change every so often, plus long holds
    initial
    begin
        int mode;
        int span;
        out_stall = 1'b0;
        hold_done = 1'b0;
        @(posedge rst_n);
        forever
        begin
            mode = $urandom_range(0, 4);
            span = $urandom_range(20, 150);
            repeat (span)
            begin
                @(negedge clk);
                if (hold_req && !hold_done)
                begin
                    hold_done = 1'b1;
                    out_stall = 1'b1;
                    repeat (LONG_HOLD - 1) @(negedge clk);
                end
                else if ($urandom_range(0, 499) == 0)
                begin
                    out_stall = 1'b1;
                    repeat ($urandom_range(20, 50)) @(negedge clk);
                end
                else
                begin
                    case (mode)
                        0:       out_stall = 1'b0;
                        1:       out_stall = ($urandom_range(0, 99) < 30);
                        2:       out_stall = ($urandom_range(0, 99) < 70);
                        3:       out_stall = (cycle_count % 3 == 0);
                        default: out_stall = ($urandom_range(0, 99) < 10);
                    endcase
                end
            end
        end
    end

    // Offer one sample and hold it until accepted
    task automatic send_sample(input sample_t s);
        @(negedge clk);
        in_valid = 1'b1;
        in_data  = s;
        do @(posedge clk); while (in_stall);
    endtask

    task automatic send_dist(input logic [DIST_W-1:0] f, l, r);
        sample_t s;
        s.front_dist = f;
        s.left_dist  = l;
        s.right_dist = r;
        send_sample(s);
    endtask

    // Idle cycles between bursts, with junk on the payload
    task automatic idle_gap(input int n);
        if (n > 0)
        begin
            @(negedge clk);
            in_valid = 1'b0;
            in_data  = sample_t'($urandom);
            repeat (n - 1) @(negedge clk);
        end
    endtask

    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx,
                             input logic [DIST_W-1:0] v);
        @(negedge clk);
        cfg_wr_en = 1'b1;
        cfg_index = idx;
        cfg_data  = v;
        @(posedge clk);
    endtask

    // Write all thresholds, and the spare indexes, which should be ignored
    task automatic load_config(input cfg_t c);
        logic [CFG_IDX_W-1:0] idx;
        write_reg(CFG_NEAR_LIMIT, c.near_limit);
        write_reg(CFG_OPEN_LIMIT, c.open_limit);
        write_reg(CFG_FAST_LIMIT, c.fast_limit);
        write_reg(CFG_LANE_LOW,   c.lane_low);
        write_reg(CFG_LANE_HIGH,  c.lane_high);
        for (idx = CFG_LANE_HIGH + CFG_IDX_W'(1); idx != '0; idx++)
            write_reg(idx, DIST_W'($urandom));
        @(negedge clk);
        cfg_wr_en  = 1'b0;
        active_cfg = c;
    endtask

    function automatic cfg_t setting_for(input int p);
        cfg_t c;
        c.near_limit = NEAR_LIMIT_RST;
        c.open_limit = OPEN_LIMIT_RST;
        c.fast_limit = FAST_LIMIT_RST;
        c.lane_low   = LANE_LOW_RST;
        c.lane_high  = LANE_HIGH_RST;
        case (p)
            1, 6:
            begin
                c.near_limit = DIST_W'($urandom_range(5, 300));
                c.open_limit = c.near_limit + DIST_W'($urandom_range(0, 200));
                c.fast_limit = DIST_W'($urandom_range(0, 1023));
                c.lane_low   = DIST_W'($urandom_range(0, 600));
                c.lane_high  = c.lane_low + DIST_W'($urandom_range(0, 100));
            end
            2: c = '0;
            3: c = '1;
            // empty lane window
            4:
            begin
                c.lane_low  = 10'd600;
                c.lane_high = 10'd400;
            end
            // thresholds out of order
            5:
            begin
                c.near_limit = DIST_MAX;
                c.open_limit = '0;
                c.fast_limit = DIST_MAX;
                c.lane_low   = '0;
                c.lane_high  = DIST_MAX;
            end
            default: ;
        endcase
        return c;
    endfunction

    // Distance near a threshold, an extreme, or anywhere
    function automatic logic [DIST_W-1:0] pick_dist();
        int roll;
        int base;
        int v;
        roll = $urandom_range(0, 99);
        if (roll < 15)
            return DIST_W'($urandom_range(0, 1023));
        if (roll < 25)
            return ($urandom_range(0, 1)) ? DIST_W'($urandom_range(0, 1))
                                          : DIST_W'($urandom_range(1022, 1023));
        case ($urandom_range(0, 4))
            0:       base = int'(active_cfg.near_limit);
            1:       base = int'(active_cfg.open_limit);
            2:       base = int'(active_cfg.fast_limit);
            3:       base = int'(active_cfg.lane_low);
            default: base = int'(active_cfg.lane_high);
        endcase
        v = base + int'($urandom_range(0, 4)) - 2;
        if (v < 0)    v = 0;
        if (v > 1023) v = 1023;
        return DIST_W'(v);
    endfunction

    // Walks the wall machine through its states under default thresholds
    task automatic run_directed();
        send_dist(10'd0,    10'd0,    10'd0);
        send_dist(DIST_MAX, 10'd10,   DIST_MAX);
        send_dist(10'd30,   10'd22,   DIST_MAX);
        send_dist(10'd100,  10'd22,   10'd100);
        send_dist(10'd100,  10'd30,   10'd100);
        send_dist(10'd100,  10'd10,   10'd100);
        send_dist(10'd100,  10'd100,  10'd10);
        send_dist(10'd100,  10'd100,  10'd23);
        send_dist(10'd100,  10'd100,  10'd30);
        send_dist(10'd100,  10'd100,  10'd5);
        send_dist(10'd10,   10'd40,   10'd10);
        send_dist(10'd100,  10'd100,  10'd100);
        send_dist(10'd10,   10'd10,   10'd40);
        send_dist(10'd10,   10'd40,   10'd40);
        send_dist(10'd100,  10'd10,   10'd100);
        send_dist(10'd10,   10'd10,   10'd10);
        send_dist(10'd0,    10'd0,    10'd0);
        send_dist(DIST_MAX, 10'd0,    DIST_MAX);
        send_dist(10'd10,   10'd40,   10'd40);
        send_dist(DIST_MAX, DIST_MAX, 10'd0);
        send_dist(10'd10,   10'd10,   10'd10);
        send_dist(DIST_MAX, DIST_MAX, DIST_MAX);
        send_dist(DIST_MAX, DIST_MAX, DIST_MAX);
        idle_gap(1);
    endtask

    // Random samples in bursts
    task automatic run_random(input int count);
        sample_t s;
        int sent;
        int burst;
        int gap_max;
        sent = 0;
        while (sent < count)
        begin
            burst   = $urandom_range(1, 24);
            gap_max = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
            repeat (burst)
            begin
                if (sent < count)
                begin
                    s.front_dist = pick_dist();
                    s.left_dist  = pick_dist();
                    s.right_dist = pick_dist();
                    send_sample(s);
                    sent++;
                end
            end
            idle_gap((gap_max == 0) ? 0 : $urandom_range(1, gap_max));
        end
        idle_gap(1);
    endtask

    task automatic wait_drained();
        while (outstanding != 0) @(negedge clk);
    endtask

    // Main sequence
    initial
    begin
        int p;
        rst_n     = 1'b0;
        cfg_wr_en = 1'b0;
        cfg_index = '0;
        cfg_data  = '0;
        in_valid  = 1'b0;
        in_data   = '0;
        hold_req  = 1'b0;
        repeat (5) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        for (p = 0; p < SETTING_COUNT; p++)
        begin
            load_config(setting_for(p));
            if (p == 0)
                run_directed();
            if (p == 1)
                hold_req = 1'b1;
            run_random(ITEMS_PER_PHASE);
            wait_drained();
        end

        repeat (DRAIN_CYCLES) @(posedge clk);
        if (failures == 0)
            $display("Verification passed");
        else
            $display("Verification failed");
        $finish;
    end

endmodule

// ----- filelist.f -----
sv/wfm_pkg.sv
sv/wfm_cfg_regs.sv
sv/wfm_decide.sv
sv/wall_follow_motion_fsm_unit.sv
bench/wall_follow_motion_fsm_unit_checker.sv
bench/wall_follow_motion_fsm_unit_tb.sv
